/* rtl/rle_delta_halfword_decoder_core_defines.svh */
// ----------------------------------------------------------------------------
// RLE delta halfword decoder - assertion macros
// Shared property wrappers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef RLE_DELTA_HALFWORD_DECODER_CORE_DEFINES_SVH
`define RLE_DELTA_HALFWORD_DECODER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, muted during reset.
`define RLDH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, muted during reset.
`define RLDH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RLDH_ASSERT_IMP(lbl, ante, cons, msg)
`define RLDH_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/rldh_pkg.sv */
// ----------------------------------------------------------------------------
// rldh_pkg
// Shared types and constants of the RLE delta halfword decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rldh_pkg;

  localparam int WORD_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int REP_W    = 9;
  localparam int BUD_W    = 10;

  localparam logic [REP_W-1:0]  FULL_RUN      = REP_W'(256);
  localparam logic [BYTE_W-1:0] BUDGET_RESET  = 8'h7f;
  localparam int                MODE_FILL_BIT = 15;
  localparam int                MODE_DELTA_BIT = 14;

  // Front-to-back queue
  localparam int QDEPTH = 2;
  localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_FIRST_HEADER = 3'd0,
    PH_HEADER       = 3'd1,
    PH_FILL_VALUE   = 3'd2,
    PH_DELTA_START  = 3'd3,
    PH_DELTA_PAIRS  = 3'd4,
    PH_RAW          = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    OP_COPY   = 2'd0,  // value is the word itself
    OP_START  = 2'd1,  // load accumulator with the word
    OP_PAIR   = 2'd2,  // two deltas, two outputs
    OP_SINGLE = 2'd3   // low-byte delta only
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] word;
    logic [REP_W-1:0]  rep;
    logic              last;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/rldh_if.sv */
// ----------------------------------------------------------------------------
// rldh channel interfaces
// Valid/ready channels for stream words, decoded results and the budget write.
// ----------------------------------------------------------------------------
`default_nettype none

interface rldh_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] stream_word;

  modport source (output valid, output stream_word, input ready);
  modport sink   (input valid, input stream_word, output ready);
endinterface

interface rldh_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;
  logic [8:0]  repeat_res;
  logic        record_last;

  modport source (output valid, output value, output repeat_res, output record_last,
                  input ready);
  modport sink   (input valid, input value, input repeat_res, input record_last,
                  output ready);
endinterface

interface rldh_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] record_budget;

  modport source (output valid, output record_budget, input ready);
  modport sink   (input valid, input record_budget, output ready);
endinterface

`default_nettype wire

/* rtl/rldh_front.sv */
// ----------------------------------------------------------------------------
// rldh_front
// Parses the token stream, tracks budget and run counts, queues work entries.
// ----------------------------------------------------------------------------
`default_nettype none

module rldh_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [rldh_pkg::WORD_W-1:0]    in_word,
  input  wire logic [rldh_pkg::BYTE_W-1:0]    record_budget,
  output logic                                push,
  output rldh_pkg::entry_t                    push_data,
  input  wire logic                           full
);

  rldh_pkg::phase_t                 phase_r, phase_nxt;
  logic [rldh_pkg::REP_W-1:0]       remaining_r, remaining_nxt;
  logic [rldh_pkg::BUD_W-1:0]       budget_r, budget_nxt;
  logic [rldh_pkg::BUD_W-1:0]       bud_base;
  logic [rldh_pkg::BYTE_W-1:0]      cnt;
  logic [rldh_pkg::REP_W-1:0]       rem_m1, rem_m2;
  logic                             neg, take;
  rldh_pkg::phase_t                 fin_phase;

  assign in_ready  = !full;
  assign take      = in_valid && in_ready;
  assign cnt       = in_word[rldh_pkg::BYTE_W-1:0];
  assign neg       = budget_r[rldh_pkg::BUD_W-1];
  assign rem_m1    = remaining_r - rldh_pkg::REP_W'(1);
  assign rem_m2    = remaining_r - rldh_pkg::REP_W'(2);
  assign fin_phase = neg ? rldh_pkg::PH_FIRST_HEADER : rldh_pkg::PH_HEADER;
  assign bud_base  = (phase_r == rldh_pkg::PH_FIRST_HEADER) ?
                     rldh_pkg::BUD_W'(record_budget) : budget_r;

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      unique case (phase_r) inside
        rldh_pkg::PH_FIRST_HEADER, rldh_pkg::PH_HEADER: begin
          if (in_word[rldh_pkg::MODE_FILL_BIT])       phase_nxt = rldh_pkg::PH_FILL_VALUE;
          else if (in_word[rldh_pkg::MODE_DELTA_BIT]) phase_nxt = rldh_pkg::PH_DELTA_START;
          else                                        phase_nxt = rldh_pkg::PH_RAW;
        end
        rldh_pkg::PH_FILL_VALUE: phase_nxt = fin_phase;
        rldh_pkg::PH_DELTA_START: begin
          phase_nxt = (rem_m1 == '0) ? fin_phase : rldh_pkg::PH_DELTA_PAIRS;
        end
        rldh_pkg::PH_DELTA_PAIRS: begin
          if (remaining_r < rldh_pkg::REP_W'(2) || rem_m2 == '0) phase_nxt = fin_phase;
        end
        rldh_pkg::PH_RAW: begin
          if (rem_m1 == '0) phase_nxt = fin_phase;
        end
        default: phase_nxt = rldh_pkg::PH_FIRST_HEADER;
      endcase
    end
  end

  // Counters and queue entry
  always_comb begin
    remaining_nxt = remaining_r;
    budget_nxt    = budget_r;
    push          = 1'b0;
    push_data     = '{op: rldh_pkg::OP_COPY, word: in_word,
                      rep: rldh_pkg::REP_W'(1), last: 1'b0};
    if (take) begin
      unique case (phase_r) inside
        rldh_pkg::PH_FIRST_HEADER, rldh_pkg::PH_HEADER: begin
          budget_nxt    = bud_base - rldh_pkg::BUD_W'(cnt);
          remaining_nxt = (cnt == '0) ? rldh_pkg::FULL_RUN : rldh_pkg::REP_W'(cnt);
        end
        rldh_pkg::PH_FILL_VALUE: begin
          push           = 1'b1;
          push_data.rep  = remaining_r;
          push_data.last = neg;
          remaining_nxt  = '0;
        end
        rldh_pkg::PH_DELTA_START: begin
          push           = 1'b1;
          push_data.op   = rldh_pkg::OP_START;
          push_data.last = (rem_m1 == '0) && neg;
          remaining_nxt  = rem_m1;
        end
        rldh_pkg::PH_DELTA_PAIRS: begin
          push = 1'b1;
          if (remaining_r >= rldh_pkg::REP_W'(2)) begin
            push_data.op   = rldh_pkg::OP_PAIR;
            push_data.last = (rem_m2 == '0) && neg;
            remaining_nxt  = rem_m2;
          end else begin
            push_data.op   = rldh_pkg::OP_SINGLE;
            push_data.last = neg;
            remaining_nxt  = '0;
          end
        end
        rldh_pkg::PH_RAW: begin
          push           = 1'b1;
          push_data.last = (rem_m1 == '0) && neg;
          remaining_nxt  = rem_m1;
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= rldh_pkg::PH_FIRST_HEADER;
      remaining_r <= '0;
      budget_r    <= rldh_pkg::BUD_W'(rldh_pkg::BUDGET_RESET);
    end else begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      budget_r    <= budget_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/rldh_fifo.sv */
// ----------------------------------------------------------------------------
// rldh_fifo
// Short entry queue between the token parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rldh_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire rldh_pkg::entry_t push_data,
  input  wire logic             pop,
  output rldh_pkg::entry_t      pop_data,
  output logic                  empty,
  output logic                  full
);

  rldh_pkg::entry_t                mem_r [rldh_pkg::QDEPTH];
  logic [rldh_pkg::PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [rldh_pkg::CNT_W-1:0]      count_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == rldh_pkg::CNT_W'(rldh_pkg::QDEPTH));
  assign pop_data = mem_r[rd_ptr_r];

  function automatic logic [rldh_pkg::PTR_W-1:0] bump(input logic [rldh_pkg::PTR_W-1:0] p);
    return (p == rldh_pkg::PTR_W'(rldh_pkg::QDEPTH - 1)) ? '0 : p + rldh_pkg::PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + rldh_pkg::CNT_W'(1);
      else if (pop && !push) count_r <= count_r - rldh_pkg::CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

/* rtl/rldh_back.sv */
// ----------------------------------------------------------------------------
// rldh_back
// Runs queued entries: delta accumulation, pair split and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rldh_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rldh_pkg::entry_t             head,
  input  wire logic                         empty,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rldh_pkg::WORD_W-1:0]       out_value,
  output logic [rldh_pkg::REP_W-1:0]        out_rep,
  output logic                              out_last
);

  logic                           out_valid_r, out_valid_nxt;
  logic [rldh_pkg::WORD_W-1:0]    value_r, value_nxt;
  logic [rldh_pkg::REP_W-1:0]     rep_r, rep_nxt;
  logic                           last_r, last_nxt;
  logic [rldh_pkg::WORD_W-1:0]    acc_r, acc_nxt;
  logic                           second_r, second_nxt;
  logic                           load, take;
  logic [rldh_pkg::WORD_W-1:0]    sum_lo, sum_hi;

  assign load   = !out_valid_r || out_ready;
  assign take   = load && !empty;
  assign sum_lo = acc_r + {{rldh_pkg::BYTE_W{head.word[7]}}, head.word[7:0]};
  assign sum_hi = acc_r + {{rldh_pkg::BYTE_W{head.word[15]}}, head.word[15:8]};

  always_comb begin
    out_valid_nxt = out_valid_r;
    value_nxt     = value_r;
    rep_nxt       = rep_r;
    last_nxt      = last_r;
    acc_nxt       = acc_r;
    second_nxt    = second_r;
    pop           = 1'b0;
    if (take) begin
      out_valid_nxt = 1'b1;
      rep_nxt       = rldh_pkg::REP_W'(1);
      last_nxt      = head.last;
      pop           = 1'b1;
      unique case (head.op)
        rldh_pkg::OP_COPY: begin
          value_nxt = head.word;
          rep_nxt   = head.rep;
        end
        rldh_pkg::OP_START: begin
          value_nxt = head.word;
          acc_nxt   = head.word;
        end
        rldh_pkg::OP_SINGLE: begin
          value_nxt = sum_lo;
          acc_nxt   = sum_lo;
        end
        rldh_pkg::OP_PAIR: begin
          if (!second_r) begin
            // low delta first; hold the entry for the high delta
            value_nxt  = sum_lo;
            acc_nxt    = sum_lo;
            last_nxt   = 1'b0;
            second_nxt = 1'b1;
            pop        = 1'b0;
          end else begin
            value_nxt  = sum_hi;
            acc_nxt    = sum_hi;
            second_nxt = 1'b0;
          end
        end
        default: value_nxt = head.word;
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
      acc_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      second_r    <= second_nxt;
      acc_r       <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    rep_r   <= rep_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = value_r;
  assign out_rep   = rep_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

/* rtl/rle_delta_halfword_decoder_core.sv */
// ----------------------------------------------------------------------------
// rle_delta_halfword_decoder_core
// Run-length / delta decoder of a record's 16-bit token stream.
// ----------------------------------------------------------------------------
//
//   channel   dir  payload                              handshake
//   in_ch     in   stream_word[15:0]                    valid/ready
//   out_ch    out  value[15:0] repeat_res[8:0] last     valid/ready
//   cfg_ch    in   record_budget[7:0]                   valid/ready, ready=1
//
// One word is taken per cycle while the two-entry queue has room. Headers
// leave no entry; a delta pair word gives two outputs in the back
// stage, which holds that entry until both are out; every other data word gives one.
// Reset is synchronous (rst_n low): budget 127, parser awaits a record
// header, queue empty, output idle. No clearing pass is needed.
// Output stalls back up through the queue into in_ch.ready only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rle_delta_halfword_decoder_core_defines.svh"

module rle_delta_halfword_decoder_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rldh_in_if.sink    in_ch,
  rldh_out_if.source out_ch,
  rldh_cfg_if.sink   cfg_ch
);

  logic [rldh_pkg::BYTE_W-1:0] budget_cfg_r;
  logic                        q_push, q_pop, q_empty, q_full;
  rldh_pkg::entry_t            q_in, q_head;

  // Budget register: always writable, picked up at the next record start.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_cfg_r <= rldh_pkg::BUDGET_RESET;
    end else if (cfg_ch.valid) begin
      budget_cfg_r <= cfg_ch.record_budget;
    end
  end

  // Parse headers, track budget, classify data words.
  rldh_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_word       (in_ch.stream_word),
    .record_budget (budget_cfg_r),
    .push          (q_push),
    .push_data     (q_in),
    .full          (q_full)
  );

  // Decouple parser from output stage.
  rldh_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Accumulate deltas, split pairs, drive the output register.
  rldh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.value),
    .out_rep   (out_ch.repeat_res),
    .out_last  (out_ch.record_last)
  );

  // Queue must never overflow nor be read empty.
  `RLDH_ASSERT_IMP(a_q_no_overflow, q_push, !q_full || q_pop, "queue push while full")
  `RLDH_ASSERT_IMP(a_q_no_underflow, q_pop, !q_empty, "queue pop while empty")
  // A queue entry always leads to a valid output on the next cycle.
  `RLDH_ASSERT_NXT(a_pop_shows_out, q_pop, out_ch.valid, "popped entry not presented")

endmodule

`default_nettype wire
